/* sv/mp22_pkg.sv */
// ----------------------------------------------------------------------------
// mp22_pkg
// Shared constants, register codes and types for the 2x2 stride-1 max pool.
// ----------------------------------------------------------------------------
package mp22_pkg;

  // default sizes
  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_PIXEL_BITS = 16;

  // configuration port
  localparam int CFG_DATA_BITS   = 16;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int WIDTH_REG_BITS  = 12;
  localparam int HEIGHT_REG_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 12'd2048;
  localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd2048;

  // row counter width
  localparam int ROW_COUNT_BITS = 16;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // per-item classification handed from front to back
  typedef struct packed {
    logic emit;
    logic last;
  } op_ctrl_t;

endpackage

/* sv/max_pool_2x2_stride1.sv */
// ----------------------------------------------------------------------------
// max_pool_2x2_stride1
// 2x2 max pooling at stride 1 over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Takes one signed pixel per clock while in_ready is high and, for every pixel
// outside the first row and first column of a frame, returns the largest pixel
// of the 2x2 window whose lower-right corner it is; the final result of a
// frame carries last_of_frame. Sustained rate is one item per cycle while the
// output is not stalled, set by the line store, which does one read and one
// write per accepted pixel. A result passes through the front register, which
// also holds the line store read, then the two-entry queue, then the output
// register. The line store holds MAX_WIDTH pixels and needs no clearing after
// reset. The user must write the frame size through the configuration port
// (index 0 width, index 1 height) only while the block is idle; the block
// itself does not enforce this.
module max_pool_2x2_stride1 #(
  parameter int MAX_WIDTH  = mp22_pkg::DEFAULT_MAX_WIDTH,
  parameter int PIXEL_BITS = mp22_pkg::DEFAULT_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mp22_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mp22_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [PIXEL_BITS-1:0]        pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [PIXEL_BITS-1:0]        pooled_max,
  output logic                                last_of_frame
);
  import mp22_pkg::*;

  localparam int CTRL_BITS  = $bits(op_ctrl_t);
  localparam int QUEUE_BITS = 2 * PIXEL_BITS + CTRL_BITS;

  logic                         push;
  logic                         push_space;
  logic signed [PIXEL_BITS-1:0] push_pixel;
  logic signed [PIXEL_BITS-1:0] push_up;
  op_ctrl_t                     push_ctrl;

  logic                         q_valid;
  logic                         q_pop;
  logic [QUEUE_BITS-1:0]        q_data;
  logic signed [PIXEL_BITS-1:0] q_pixel;
  logic signed [PIXEL_BITS-1:0] q_up;
  op_ctrl_t                     q_ctrl;

  // front: counters, classification, line store
  mp22_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel),
    .push       (push),
    .push_space (push_space),
    .push_pixel (push_pixel),
    .push_up    (push_up),
    .push_ctrl  (push_ctrl)
  );

  // queue between front and back
  mp22_queue #(
    .DATA_BITS (QUEUE_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_pixel, push_up, push_ctrl}),
    .space     (push_space),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  assign q_pixel = q_data[QUEUE_BITS-1 -: PIXEL_BITS];
  assign q_up    = q_data[CTRL_BITS +: PIXEL_BITS];
  assign q_ctrl  = q_data[CTRL_BITS-1:0];

  // back: window history, maximum, output register
  mp22_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_pixel       (q_pixel),
    .q_up          (q_up),
    .q_ctrl        (q_ctrl),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pooled_max    (pooled_max),
    .last_of_frame (last_of_frame)
  );

endmodule

/* sv/mp22_ram.sv */
// ----------------------------------------------------------------------------
// mp22_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mp22_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

/* sv/mp22_queue.sv */
// ----------------------------------------------------------------------------
// mp22_queue
// Short register queue between the front and the back of the pool.
// ----------------------------------------------------------------------------
module mp22_queue #(
  parameter int DATA_BITS = 34
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 space,
  input  logic                 pop,
  output logic                 valid,
  output logic [DATA_BITS-1:0] pop_data
);
  import mp22_pkg::*;

  localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0]  entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;

  assign space    = (count < COUNT_BITS'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_BITS'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/mp22_front.sv */
// ----------------------------------------------------------------------------
// mp22_front
// Accepts pixels, tracks row and column, classifies each item and reads the
// pixel above from the line store.
// ----------------------------------------------------------------------------
module mp22_front #(
  parameter int MAX_WIDTH  = mp22_pkg::DEFAULT_MAX_WIDTH,
  parameter int PIXEL_BITS = mp22_pkg::DEFAULT_PIXEL_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [mp22_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [mp22_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [PIXEL_BITS-1:0]          pixel,
  output logic                                  push,
  input  logic                                  push_space,
  output logic signed [PIXEL_BITS-1:0]          push_pixel,
  output logic signed [PIXEL_BITS-1:0]          push_up,
  output mp22_pkg::op_ctrl_t                    push_ctrl
);
  import mp22_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > WIDTH_REG_BITS) ? CW + 1 : WIDTH_REG_BITS;

  logic [WIDTH_REG_BITS-1:0]  image_width;
  logic [HEIGHT_REG_BITS-1:0] image_height;
  logic [CW-1:0]              col;
  logic [ROW_COUNT_BITS-1:0]  row;

  logic                       accept;
  logic [WW-1:0]              w_ext;
  logic [WW-1:0]              w_eff;
  logic [WW-1:0]              last_col;
  logic [HEIGHT_REG_BITS-1:0] h_eff;
  logic [HEIGHT_REG_BITS-1:0] last_row;
  logic                       end_row;
  logic                       end_frame;
  op_ctrl_t                   ctrl_next;

  logic                       f_valid;
  logic signed [PIXEL_BITS-1:0] f_pixel;
  op_ctrl_t                   f_ctrl;
  logic [PIXEL_BITS-1:0]      up_raw;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame size and find row and frame ends
  always_comb begin
    w_ext = WW'(image_width);
    if (w_ext < WW'(2)) begin
      w_eff = WW'(2);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    last_col  = w_eff - WW'(1);
    h_eff     = (image_height < HEIGHT_REG_BITS'(2)) ? HEIGHT_REG_BITS'(2) : image_height;
    last_row  = h_eff - HEIGHT_REG_BITS'(1);
    end_row   = (WW'(col) >= last_col);
    end_frame = end_row && (row >= last_row);
    ctrl_next.emit = (row != '0) && (col != '0);
    ctrl_next.last = end_frame;
  end

  // handshake: hold the item until the queue takes it
  assign push     = f_valid && push_space;
  assign in_ready = !f_valid || push_space;
  assign accept   = in_valid && in_ready;

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (end_row) begin
        col <= '0;
        row <= end_frame ? '0 : row + ROW_COUNT_BITS'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // item register in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_pixel <= pixel;
      f_ctrl  <= ctrl_next;
    end
  end

  // line store: previous row, read and overwritten at the same column
  mp22_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (pixel),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (up_raw)
  );

  assign push_pixel = f_pixel;
  assign push_up    = up_raw;
  assign push_ctrl  = f_ctrl;

endmodule

/* sv/mp22_back.sv */
// ----------------------------------------------------------------------------
// mp22_back
// Keeps the left and upper-left pixels, forms the window maximum and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module mp22_back #(
  parameter int PIXEL_BITS = mp22_pkg::DEFAULT_PIXEL_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic signed [PIXEL_BITS-1:0] q_pixel,
  input  logic signed [PIXEL_BITS-1:0] q_up,
  input  mp22_pkg::op_ctrl_t           q_ctrl,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [PIXEL_BITS-1:0] pooled_max,
  output logic                         last_of_frame
);
  import mp22_pkg::*;

  logic signed [PIXEL_BITS-1:0] left_pixel;
  logic signed [PIXEL_BITS-1:0] upper_left_pixel;
  logic signed [PIXEL_BITS-1:0] max_lower;
  logic signed [PIXEL_BITS-1:0] max_upper;
  logic signed [PIXEL_BITS-1:0] best;

  // take the next item once the output register is free or draining
  assign q_pop = q_valid && (!out_valid || out_ready);

  // window maximum
  always_comb begin
    max_lower = (q_pixel > left_pixel) ? q_pixel : left_pixel;
    max_upper = (q_up > upper_left_pixel) ? q_up : upper_left_pixel;
    best      = (max_lower > max_upper) ? max_lower : max_upper;
  end

  // window history and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (q_pop) begin
        left_pixel       <= q_pixel;
        upper_left_pixel <= q_up;
      end
      if (q_pop && q_ctrl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop && q_ctrl.emit) begin
      pooled_max    <= best;
      last_of_frame <= q_ctrl.last;
    end
  end

endmodule

/* sv/mp22_checker.sv */
// ----------------------------------------------------------------------------
// mp22_checker
// Port-level checks on the max pool, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mp22_checker #(
  parameter int PIXEL_BITS = mp22_pkg::DEFAULT_PIXEL_BITS
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [PIXEL_BITS-1:0] pooled_max,
  input logic                         last_of_frame
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pooled_max) && $stable(last_of_frame))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // a draining output keeps the input open in the next cycle
  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    out_ready |=> in_ready)
    else $error("input stalled although output drains");

  // a waiting input item stays valid
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input item dropped before acceptance");

endmodule

bind max_pool_2x2_stride1 mp22_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pooled_max    (pooled_max),
  .last_of_frame (last_of_frame)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x2 stride-1 max pool. A scoreboard keeps its
// own line store, neighbor registers and counters, predicts the pooled result
// of every accepted pixel past the first row and column, compares each output
// item field by field. Directed frames hit the pixel extremes, clamped sizes
// and a mid-frame size change; random frames of mostly small sizes follow,
// with random stalls on both sides and one wide frame run without stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mp22_pkg::*;

  localparam int PIX_BITS  = DEFAULT_PIXEL_BITS;
  localparam int LINE_SIZE = DEFAULT_MAX_WIDTH;
  localparam int DRAIN_CYCLES = 10;
  localparam int WIDE_COLS  = 128;
  localparam int RAND_ITEMS = 1020;

  typedef logic signed [PIX_BITS-1:0] pix_t;

  typedef struct {
    pix_t value;
    logic last;
  } pooled_t;

  // predicts pooled results and checks the output stream
  class max_pool_scoreboard;
    logic [WIDTH_REG_BITS-1:0]  width_reg;
    logic [HEIGHT_REG_BITS-1:0] height_reg;
    pix_t                       line_buf [LINE_SIZE];
    pix_t                       left_px;
    pix_t                       upleft_px;
    logic [10:0]                col_cnt;
    logic [ROW_COUNT_BITS-1:0]  row_cnt;
    pooled_t                    pending_pools [$];
    int                         errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (line_buf[i]) line_buf[i] = '0;
      left_px   = '0;
      upleft_px = '0;
      col_cnt   = '0;
      row_cnt   = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_IMAGE_WIDTH) width_reg = data[WIDTH_REG_BITS-1:0];
      else if (idx == REG_IMAGE_HEIGHT) height_reg = data[HEIGHT_REG_BITS-1:0];
    endfunction

    function int pending();
      return pending_pools.size();
    endfunction

    // advance the window by one accepted pixel
    function void pool_pixel(pix_t px);
      int unsigned w;
      int unsigned h;
      int unsigned slot;
      pix_t        above;
      pix_t        best;
      logic        end_row;
      logic        end_frame;
      pooled_t     res;
      w = width_reg;
      h = height_reg;
      if (w < 2) w = 2;
      if (w > LINE_SIZE) w = LINE_SIZE;
      if (h < 2) h = 2;
      slot      = col_cnt % LINE_SIZE;
      above     = line_buf[slot];
      end_row   = (col_cnt >= w - 1);
      end_frame = end_row && (row_cnt >= h - 1);
      // no window in the first row or first column
      if (row_cnt != 0 && col_cnt != 0) begin
        best = px;
        if (left_px > best) best = left_px;
        if (above > best) best = above;
        if (upleft_px > best) best = upleft_px;
        res.value = best;
        res.last  = end_frame;
        pending_pools.push_back(res);
      end
      upleft_px      = above;
      left_px        = px;
      line_buf[slot] = px;
      if (end_row) begin
        col_cnt = '0;
        row_cnt = end_frame ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt = col_cnt + 1'b1;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 50) $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare one output item with the oldest prediction
    task check_result(pix_t value, logic last);
      pooled_t exp_res;
      if (pending_pools.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d last %0b", value, last));
      end else begin
        exp_res = pending_pools.pop_front();
        if (value !== exp_res.value)
          report_mismatch($sformatf("pooled_max %0d, want %0d", value, exp_res.value));
        if (last !== exp_res.last)
          report_mismatch($sformatf("last_of_frame %0b, want %0b", last, exp_res.last));
      end
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  pix_t                      pixel = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  pix_t                      pooled_max;
  logic                      last_of_frame;
  logic                      no_idle = 1'b0;

  max_pool_scoreboard sb = new();

  max_pool_2x2_stride1 u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel         (pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pooled_max    (pooled_max),
    .last_of_frame (last_of_frame)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // output side stalls
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 36);
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(pooled_max, last_of_frame);
  end

  // one pixel item, with random idle cycles ahead of it
  task automatic send_pixel(input pix_t px);
    while (!no_idle && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.pool_pixel(px);
  endtask

  task automatic send_list(input int list [$]);
    foreach (list[i]) send_pixel(pix_t'(list[i]));
  endtask

  // hold the input until every predicted result is out and the pipe is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_size(input logic [CFG_DATA_BITS-1:0] wdata,
                                  input logic [CFG_DATA_BITS-1:0] hdata);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= wdata;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= hdata;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(REG_IMAGE_WIDTH, wdata);
    sb.write_reg(REG_IMAGE_HEIGHT, hdata);
  endtask

  // random pixel with a chosen flavor
  function automatic pix_t rand_pixel(input int mode);
    int v;
    case (mode)
      1: v = $urandom_range(0, 6) - 3;
      2: begin
        case ($urandom_range(0, 5))
          0: v = -32768;
          1: v = 32767;
          2: v = -32767;
          3: v = 32766;
          4: v = 0;
          default: v = -1;
        endcase
      end
      3: v = -32768 + $urandom_range(0, 15);
      default: v = $urandom_range(0, 65535);
    endcase
    return pix_t'(v);
  endfunction

  // stimulus
  initial begin
    int                       rand_items;
    int unsigned              w;
    int unsigned              h;
    int unsigned              n;
    int                       mode;
    logic [CFG_DATA_BITS-1:0] wdata;
    logic [CFG_DATA_BITS-1:0] hdata;
    rand_items = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // clamped 2x2 frames: all most-negative, then mixed extremes
    write_frame_size(16'd1, 16'd0);
    send_list('{-32768, -32768, -32768, -32768});
    send_list('{32767, -32768, 0, -1});

    // 3x3 frame with sign boundaries
    wait_drained();
    write_frame_size(16'd3, 16'd3);
    send_list('{-1, 0, 1, -32768, 32767, -2, 5, -5, -32768});

    // tallest frame cut short by a smaller height mid-frame
    wait_drained();
    write_frame_size(16'd2, 16'hFFFF);
    send_list('{7, -7, 100, -100, 32767, 32767});
    wait_drained();
    write_frame_size(16'd2, 16'd3);
    send_list('{-32768, 1});

    // wide frame with no stalls on either side, covers every column the
    // random frames reach in the line store
    wait_drained();
    write_frame_size(16'(WIDE_COLS), 16'd2);
    no_idle = 1'b1;
    repeat (2 * WIDE_COLS) send_pixel(rand_pixel(0));
    wait_drained();
    no_idle = 1'b0;

    // random frames, mostly small, some ended mid-frame
    while (rand_items < RAND_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 120) : $urandom_range(2, 12);
      h = $urandom_range(2, 6);
      wdata = w;
      hdata = h;
      if (w == 2 && $urandom_range(0, 1) == 1) wdata = $urandom_range(0, 1);
      if (h == 2 && $urandom_range(0, 1) == 1) hdata = $urandom_range(0, 1);
      wdata[CFG_DATA_BITS-1:WIDTH_REG_BITS] = $urandom_range(0, 15);
      wait_drained();
      write_frame_size(wdata, hdata);
      mode = $urandom_range(0, 3);
      n = w * h * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n - 1);
      if (n > RAND_ITEMS - rand_items) n = RAND_ITEMS - rand_items;
      repeat (n) begin
        send_pixel(rand_pixel(mode));
        rand_items++;
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    // let the last results out
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
